@@ rtl/core/pbfs_pkg.sv @@
`default_nettype none
package pbfs_pkg;

  localparam int STORE_WORDS = 1024;
  localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int WORD_W      = 16;
  localparam int REF_W       = 14;
  localparam int POS_W       = 4;
  localparam int LOG_W       = 3;
  localparam int VAL_W       = 4;

  localparam logic [LOG_W-1:0] LOG_MAX         = 3'd4;
  localparam logic [LOG_W-1:0] FIELD_LOG_RESET = 3'd2;

  localparam logic [2:0] REQ_GET_VALUE = 3'd0;
  localparam logic [2:0] REQ_GET_BIT   = 3'd1;
  localparam logic [2:0] REQ_TRY_SET   = 3'd2;
  localparam logic [2:0] REQ_TRY_CLEAR = 3'd3;
  localparam logic [2:0] REQ_INC       = 3'd4;
  localparam logic [2:0] REQ_DEC       = 3'd5;

  // Decoded request carried from acceptance to the modify stage
  typedef struct packed {
    logic [2:0]        req;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  bidx;
    logic [LOG_W-1:0]  lg;
    logic              oor;
    logic [ADDR_W-1:0] addr;
  } op_t;

  // Modify stage outcome: result fields and write-back
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              flag;
    logic              err;
    logic              we;
    logic [WORD_W-1:0] wdata;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/pbfs_decode.sv @@
`default_nettype none
module pbfs_decode (
  input  wire logic [pbfs_pkg::LOG_W-1:0] field_log,
  input  wire logic [2:0]                 req_type,
  input  wire logic [pbfs_pkg::REF_W-1:0] entry_ref,
  input  wire logic [pbfs_pkg::POS_W-1:0] bit_index,
  output pbfs_pkg::op_t                   op
);
  import pbfs_pkg::*;

  localparam int OFF_W = REF_W + POS_W;

  logic [LOG_W-1:0] lg;
  logic [OFF_W-1:0] offset;
  logic [REF_W-1:0] widx;

  always_comb begin
    lg     = (field_log > LOG_MAX) ? LOG_MAX : field_log;
    offset = {{POS_W{1'b0}}, entry_ref} << lg;
    widx   = offset[OFF_W-1:POS_W];

    op.req  = req_type;
    op.pos  = offset[POS_W-1:0];
    op.bidx = bit_index;
    op.lg   = lg;
    op.oor  = (32'(widx) >= 32'(STORE_WORDS));
    op.addr = ADDR_W'(widx);
  end

endmodule
`default_nettype wire

@@ rtl/core/pbfs_mem.sv @@
`default_nettype none
module pbfs_mem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [pbfs_pkg::ADDR_W-1:0] rd_addr,
  output logic      [pbfs_pkg::WORD_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [pbfs_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [pbfs_pkg::WORD_W-1:0] wr_data,
  output logic                             clr_busy
);
  import pbfs_pkg::*;

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  always_comb begin
    we    = clr_busy_r || wr_en;
    waddr = clr_busy_r ? clr_addr_r : wr_addr;
    wdata = clr_busy_r ? '0 : wr_data;
  end

  // Zero one word per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(STORE_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward a same-edge write-back so back-to-back items see fresh data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

@@ rtl/core/pbfs_alu.sv @@
`default_nettype none
module pbfs_alu (
  input  wire logic [pbfs_pkg::WORD_W-1:0] word,
  input  wire pbfs_pkg::op_t               op,
  output pbfs_pkg::res_t                   res
);
  import pbfs_pkg::*;

  logic [WORD_W-1:0] sh;
  logic [VAL_W-1:0]  mask;
  logic [VAL_W-1:0]  cnt;
  logic [POS_W:0]    bpos;
  logic [WORD_W-1:0] bmask;
  logic [WORD_W-1:0] unit;
  logic [WORD_W-1:0] nw_inc;
  logic [WORD_W-1:0] nw_dec;
  logic [WORD_W-1:0] sh_inc;
  logic [WORD_W-1:0] sh_dec;
  logic              ovf;

  always_comb begin
    sh     = word >> op.pos;
    mask   = VAL_W'((5'd1 << op.lg) - 5'd1);
    cnt    = sh[VAL_W-1:0] & mask;
    bpos   = {1'b0, op.bidx} + {1'b0, op.pos};
    bmask  = bpos[POS_W] ? '0 : (WORD_W'(1) << bpos[POS_W-1:0]);
    unit   = WORD_W'(1) << op.pos;
    nw_inc = word + unit;
    nw_dec = word - unit;
    sh_inc = nw_inc >> op.pos;
    sh_dec = nw_dec >> op.pos;
    // zero width counter never overflows
    ovf    = (op.lg != '0) && (cnt >= (VAL_W'(op.lg) - 4'd1));

    res = '0;
    res.wdata = word;
    if (op.oor) begin
      res.err = (op.req <= REQ_DEC);
    end else begin
      case (op.req)
        REQ_GET_VALUE: res.value = cnt;
        REQ_GET_BIT:   res.flag  = |(word & bmask);
        REQ_TRY_SET: begin
          res.flag  = (bmask != '0) && ((word & bmask) == '0);
          res.we    = 1'b1;
          res.wdata = word | bmask;
        end
        REQ_TRY_CLEAR: begin
          res.flag  = |(word & bmask);
          res.we    = 1'b1;
          res.wdata = word & ~bmask;
        end
        REQ_INC: begin
          if (ovf) begin
            res.err = 1'b1;
          end else begin
            res.we    = 1'b1;
            res.wdata = nw_inc;
            res.value = sh_inc[VAL_W-1:0] & mask;
          end
        end
        REQ_DEC: begin
          if (cnt == '0) begin
            res.err = 1'b1;
          end else begin
            res.we    = 1'b1;
            res.wdata = nw_dec;
            res.value = sh_dec[VAL_W-1:0] & mask;
          end
        end
        default: res.we = 1'b0;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/packed_bit_field_store_core.sv @@
`default_nettype none
// Packed bit-field store: 1024 words of 16 bits holding small entries spaced
// 2**field_log bits apart (field_log capped at 4). One item is accepted per
// cycle while in_stall is low; its result goes from the modify stage into
// the output register: the word is read when the item is accepted, then
// modified and written back as the item moves into the output register, with
// a bypass so an item that follows at once sees the previous write. The
// memory's single write port and registered read shape this pipeline. After
// reset the block clears all 1024 words, one word per cycle, and holds
// in_stall high meanwhile; cfg writes are taken at any time (cfg_ready is
// always high) but should only be made while no item is in flight.
module packed_bit_field_store_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pbfs_pkg::LOG_W-1:0]  cfg_field_log,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_req_type,
  input  wire logic [pbfs_pkg::REF_W-1:0]  in_entry_ref,
  input  wire logic [pbfs_pkg::POS_W-1:0]  in_bit_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [pbfs_pkg::VAL_W-1:0]  out_value_out,
  output logic                             out_flag_out,
  output logic                             out_error
);
  import pbfs_pkg::*;

  logic [LOG_W-1:0]  field_log_r;
  op_t               dec_op;
  op_t               s1_op_r;
  logic              s1_valid_r;
  logic [WORD_W-1:0] rd_word;
  res_t              res;
  logic              clr_busy;
  logic              in_acc;
  logic              advance;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_flag_r;
  logic              out_error_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_log_r <= FIELD_LOG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      field_log_r <= cfg_field_log;
    end
  end

  pbfs_decode u_decode (
    .field_log (field_log_r),
    .req_type  (in_req_type),
    .entry_ref (in_entry_ref),
    .bit_index (in_bit_index),
    .op        (dec_op)
  );

  // Modify stage advances when the output register is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy || (s1_valid_r && !advance);
  assign in_acc   = in_valid && !in_stall;

  pbfs_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (dec_op.addr),
    .rd_data  (rd_word),
    .wr_en    (advance && res.we),
    .wr_addr  (s1_op_r.addr),
    .wr_data  (res.wdata),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= dec_op;
    end
  end

  pbfs_alu u_alu (
    .word (rd_word),
    .op   (s1_op_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value_r <= res.value;
      out_flag_r  <= res.flag;
      out_error_r <= res.err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_flag_out  = out_flag_r;
  assign out_error     = out_error_r;

endmodule
`default_nettype wire

@@ rtl/core/pbfs_checker.sv @@
`default_nettype none
module pbfs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [pbfs_pkg::VAL_W-1:0] out_value_out,
  input wire logic                       out_flag_out,
  input wire logic                       out_error
);

  // The clearing pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted during clearing pass");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out)
      && $stable(out_flag_out) && $stable(out_error))
    else $error("stalled result changed");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> (out_value_out == '0) && !out_flag_out)
    else $error("error result carries a value or flag");

  a_flag_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag_out |-> (out_value_out == '0))
    else $error("bit result carries a counter value");

endmodule

bind packed_bit_field_store_core pbfs_checker u_pbfs_checker (.*);
`default_nettype wire
